>>> hdl/assert_macros.svh
// Assertion macros shared by the mixer RTL.
// No dependencies; the assertion bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at each rising edge outside reset.
`define ACMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mixer assertion failed");
// Next-cycle implication, checked at each rising edge outside reset.
`define ACMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mixer assertion failed");
`else
`define ACMM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ACMM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/acmm_pkg.sv
// Package for the ambisonic channel matrix mixer.
// It holds the opcodes, the fixed field widths and the sequencer state type.
// It has no dependencies.
package acmm_pkg;

	localparam int COEF_BITS  = 24;
	localparam int INDEX_BITS = 8;
	localparam int CHAN_BITS  = 4;
	localparam int FRAC_SHIFT = 20;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} seq_state_t;

endpackage

>>> hdl/ambisonic_channel_matrix_mixer_unit.sv
// After the last sample of a frame, the output channels are computed in turn on the one
// shared multiply-accumulate: the coefficient and sample reads are registered, then the
// product, then the accumulator, and each sum leaves through the result register.
// Loads and samples are accepted only while the sequencer is idle.
// Reset (arst_n low) clears the sample count, the sequencer, the result valid flag and,
// through per-entry valid bits, the coefficients. Depends on acmm_pkg, assert_macros.svh.
`include "assert_macros.svh"

module ambisonic_channel_matrix_mixer_unit #(
	parameter int CHANNELS    = 7,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item channel
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 opcode,
	input  logic [acmm_pkg::INDEX_BITS-1:0]      coef_index,
	input  logic signed [acmm_pkg::COEF_BITS-1:0] coef_value,
	input  logic signed [SAMPLE_BITS-1:0]        sample_value,
	// result channel
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [acmm_pkg::CHAN_BITS-1:0]       out_channel,
	output logic signed [SAMPLE_BITS-1:0]        out_value,
	output logic                                 out_last
);

	localparam int NUM_COEFS = CHANNELS * CHANNELS;
	localparam int AW        = $clog2(NUM_COEFS);
	localparam int CW        = $clog2(CHANNELS);
	localparam int PW        = acmm_pkg::COEF_BITS + SAMPLE_BITS;
	localparam int ACC_W     = PW + $clog2(CHANNELS);
	localparam int SH_W      = ACC_W - acmm_pkg::FRAC_SHIFT;

	localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

	// Sequencer state and counters.
	acmm_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;      // next sample slot within the frame
	logic [CW-1:0] k_q;        // output channel under computation
	logic [CW-1:0] i_q;        // input channel of the next product
	logic [AW-1:0] rd_addr_q;  // k_q + CHANNELS*i_q, stepped by CHANNELS

	// Coefficient store: memory with one write and one read port, plus valid bits.
	logic [acmm_pkg::COEF_BITS-1:0] coef_mem [NUM_COEFS];
	logic [NUM_COEFS-1:0]           coef_vld_q;

	// Frame sample registers.
	logic signed [SAMPLE_BITS-1:0] samp_q [CHANNELS];

	// MAC pipeline.
	logic                                 v_s1, last_s1, hit_s1;
	logic [acmm_pkg::COEF_BITS-1:0]       coef_raw_s1;
	logic signed [acmm_pkg::COEF_BITS-1:0] coef_s1;
	logic signed [SAMPLE_BITS-1:0]        samp_s1;
	logic                                 v_s2, last_s2;
	logic signed [PW-1:0]                 prod_s2;
	logic signed [ACC_W-1:0]              acc_q;

	// Result register.
	logic                          result_valid_q;
	logic [acmm_pkg::CHAN_BITS-1:0] out_channel_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q;
	logic                          out_last_q;

	// Control decoded from state and handshakes.
	logic item_fire, load_fire, samp_fire, frame_done, in_range;
	logic issue, issue_last, emit_fire, out_free;

	logic signed [SH_W-1:0]        sh;
	logic                          fits;
	logic signed [SAMPLE_BITS-1:0] sat_value;

	assign item_stall = (state_q != acmm_pkg::ST_IDLE);
	assign item_fire  = item_valid && !item_stall;
	assign load_fire  = item_fire && (opcode == acmm_pkg::OP_LOAD);
	assign samp_fire  = item_fire && (opcode == acmm_pkg::OP_SAMPLE);
	assign frame_done = samp_fire && (cnt_q == LAST_CH);
	assign in_range   = (coef_index < acmm_pkg::INDEX_BITS'(NUM_COEFS));

	// Result register frees up when empty or when the held transaction leaves.
	assign out_free = !result_valid_q || !result_stall;

	// Next state and sequencer strobes.
	always_comb begin
		state_d    = state_q;
		issue      = 1'b0;
		issue_last = 1'b0;
		emit_fire  = 1'b0;
		unique case (state_q)
			acmm_pkg::ST_IDLE: begin
				if (frame_done) begin
					state_d = acmm_pkg::ST_MAC;
				end
			end
			acmm_pkg::ST_MAC: begin
				issue      = 1'b1;
				issue_last = (i_q == LAST_CH);
				if (issue_last) begin
					state_d = acmm_pkg::ST_DRAIN;
				end
			end
			acmm_pkg::ST_DRAIN: begin
				// The last product lands in the accumulator at this edge.
				if (v_s2 && last_s2) begin
					state_d = acmm_pkg::ST_EMIT;
				end
			end
			acmm_pkg::ST_EMIT: begin
				if (out_free) begin
					emit_fire = 1'b1;
					state_d   = (k_q == LAST_CH) ? acmm_pkg::ST_IDLE : acmm_pkg::ST_MAC;
				end
			end
			default: begin
				state_d = acmm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the sample slot, output channel and product counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			k_q       <= '0;
			i_q       <= '0;
			rd_addr_q <= '0;
		end else begin
			if (samp_fire) begin
				cnt_q <= frame_done ? '0 : cnt_q + 1'b1;
			end
			if (frame_done) begin
				k_q       <= '0;
				i_q       <= '0;
				rd_addr_q <= '0;
			end else if (issue) begin
				i_q       <= issue_last ? '0 : i_q + 1'b1;
				rd_addr_q <= rd_addr_q + AW'(CHANNELS);
			end else if (emit_fire) begin
				k_q       <= k_q + 1'b1;
				rd_addr_q <= AW'(k_q) + 1'b1;
			end
		end
	end

	// Coefficient memory: write on a load in range, registered read at all times.
	always_ff @(posedge clk) begin
		if (load_fire && in_range) begin
			coef_mem[coef_index[AW-1:0]] <= coef_value;
		end
		coef_raw_s1 <= coef_mem[rd_addr_q];
	end

	// Mark written entries; an unmarked entry reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			hit_s1     <= 1'b0;
		end else begin
			if (load_fire && in_range) begin
				coef_vld_q[coef_index[AW-1:0]] <= 1'b1;
			end
			hit_s1 <= coef_vld_q[rd_addr_q];
		end
	end

	assign coef_s1 = hit_s1 ? $signed(coef_raw_s1) : '0;

	// Frame samples land in their slot in arrival order.
	always_ff @(posedge clk) begin
		if (samp_fire) begin
			samp_q[cnt_q] <= sample_value;
		end
		samp_s1 <= samp_q[i_q];
	end

	// Pipeline valids and the end-of-sum marker.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= issue;
			last_s1 <= issue && issue_last;
			v_s2    <= v_s1;
			last_s2 <= v_s1 && last_s1;
		end
	end

	// One shared multiplier, registered before the accumulator.
	always_ff @(posedge clk) begin
		prod_s2 <= coef_s1 * samp_s1;
	end

	// Accumulate products; drop the sum once it has been emitted or when a frame completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (emit_fire || frame_done) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Floor shift, then clamp to the sample range.
	assign sh        = SH_W'(acc_q >>> acmm_pkg::FRAC_SHIFT);
	assign fits      = (&sh[SH_W-1:SAMPLE_BITS-1]) || !(|sh[SH_W-1:SAMPLE_BITS-1]);
	assign sat_value = fits ? sh[SAMPLE_BITS-1:0]
		: (sh[SH_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

	// Result register: hold while stalled, load on emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_channel_q <= acmm_pkg::CHAN_BITS'(k_q);
			out_value_q   <= sat_value;
			out_last_q    <= (k_q == LAST_CH);
		end
	end

	assign result_valid = result_valid_q;
	assign out_channel  = out_channel_q;
	assign out_value    = out_value_q;
	assign out_last     = out_last_q;

	// A frame is always complete while its results are computed.
	`ACMM_ASSERT_NOW(a_cnt_idle_in_compute, clk, arst_n, state_q != acmm_pkg::ST_IDLE, cnt_q == '0)
	// The final product of a sum only arrives while draining.
	`ACMM_ASSERT_NOW(a_last_in_drain, clk, arst_n, v_s2 && last_s2, state_q == acmm_pkg::ST_DRAIN)
	// The read address tracks the coefficient position of the current term.
	`ACMM_ASSERT_NOW(a_addr_track, clk, arst_n, state_q == acmm_pkg::ST_MAC, rd_addr_q == AW'(k_q) + AW'(CHANNELS) * AW'(i_q))
	// An emit always leaves a valid result behind.
	`ACMM_ASSERT_NEXT(a_emit_valid, clk, arst_n, emit_fire, result_valid_q)

endmodule
